// File: hw/rtl/mrf_pkg.sv
// Shared types, codes and constants of the mip residency feedback policy block.
package mrf_pkg;

  localparam int SLOT_W          = 10;
  localparam int SLOT_SPACE      = 1 << SLOT_W;
  localparam int SLOTS_DEFAULT   = 1024;
  localparam int REG_W           = 7;
  localparam int IN_TDATA_W      = 64;
  localparam int IN_TUSER_W      = 3;
  localparam int OUT_TDATA_W     = 16;

  localparam logic [REG_W-1:0] HOLD_STEP_RESET  = 7'd4;
  localparam logic [REG_W-1:0] HOLD_LIMIT_RESET = 7'd120;

  localparam logic CFG_HOLD_STEP  = 1'b0;
  localparam logic CFG_HOLD_LIMIT = 1'b1;

  localparam logic [2:0] FUNC_FEEDBACK = 3'd0;
  localparam logic [2:0] FUNC_RESIDENT = 3'd1;
  localparam logic [2:0] FUNC_BEGIN    = 3'd2;
  localparam logic [2:0] FUNC_END      = 3'd3;
  localparam logic [2:0] FUNC_REMOVE   = 3'd4;

  typedef enum logic [2:0] {
    OP_FEEDBACK = 3'd0,
    OP_RESIDENT = 3'd1,
    OP_BEGIN    = 3'd2,
    OP_END      = 3'd3,
    OP_REMOVE   = 3'd4,
    OP_NONE     = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        in_range;
    logic [9:0]  slot;
    logic        slot_live;
    logic        wanted_valid;
    logic [3:0]  wanted_mip;
    logic [3:0]  lod_base;
    logic [3:0]  tex_format;
    logic [14:0] phys_width;
    logic [14:0] phys_height;
    logic [3:0]  phys_mips;
  } item_t;

  typedef struct packed {
    logic        alive;
    logic        pending;
    logic [3:0]  format;
    logic [14:0] width;
    logic [14:0] height;
    logic [3:0]  total;
    logic [3:0]  target;
    logic [3:0]  resident;
    logic [6:0]  hold;
    logic        demand;
  } rec_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] target_mip;
    logic [3:0] resident_mip;
    logic       demand;
    logic       upgraded;
    logic       downgraded;
    logic       sampled;
  } res_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

// File: hw/rtl/mip_residency_feedback_policy_core.sv
// Top level of the mip residency feedback policy block.
// Each texture slot keeps one residency record in an on-chip table; every input
// transaction reads its slot's record and updates it, writing it back if the slot is
// in range, and gives one result transaction. An item passes the execution side as a
// table read, then an update and write-back of the same entry, and the execution side
// takes no new item until the last one is written back; a two-entry input queue and
// an output register let either side stall without blocking the other. After reset
// the table is cleared one entry per cycle, min(SLOTS, 1024) entries, while no input
// is taken; configuration writes are accepted at any time.
module mip_residency_feedback_policy_core
  import mrf_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // slot, slot_live, wanted_valid, wanted_mip, lod_base, tex_format, phys_width,
  // phys_height, phys_mips
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // accepted, target_mip, resident_mip, demand, upgraded, downgraded, sampled
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int DEPTH = (SLOTS < SLOT_SPACE) ? SLOTS : SLOT_SPACE;

  logic [REG_W-1:0] hold_step;
  logic [REG_W-1:0] hold_limit;
  back_ctl_t        ctl;
  logic             head_valid;
  item_t            head;
  res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_step  <= HOLD_STEP_RESET;
      hold_limit <= HOLD_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HOLD_STEP:  hold_step  <= cfg_data;
        CFG_HOLD_LIMIT: hold_limit <= cfg_data;
        default:        hold_step  <= hold_step;
      endcase
    end
  end

  mrf_front #(.SLOTS(SLOTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .ctl           (ctl),
    .head_valid    (head_valid),
    .head          (head)
  );

  mrf_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .ctl        (ctl),
    .hold_step  (hold_step),
    .hold_limit (hold_limit),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_res    (res)
  );

  assign m_axis_tdata = {3'd0, res.sampled, res.downgraded, res.upgraded, res.demand,
                         res.resident_mip, res.target_mip, res.accepted};

endmodule

// File: hw/rtl/mrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mrf_front.sv
// Input side: accepts transactions, decodes the function and range, and queues them.
module mrf_front
  import mrf_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [IN_TUSER_W-1:0] s_axis_tuser,
  input  back_ctl_t             ctl,
  output logic                  head_valid,
  output item_t                 head
);

  localparam logic [16:0] SLOT_LIMIT = 17'(SLOTS);

  item_t      q [2];
  item_t      incoming;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    case (s_axis_tuser)
      FUNC_FEEDBACK: incoming.op = OP_FEEDBACK;
      FUNC_RESIDENT: incoming.op = OP_RESIDENT;
      FUNC_BEGIN:    incoming.op = OP_BEGIN;
      FUNC_END:      incoming.op = OP_END;
      FUNC_REMOVE:   incoming.op = OP_REMOVE;
      default:       incoming.op = OP_NONE;
    endcase
    incoming.slot         = s_axis_tdata[9:0];
    incoming.in_range     = {7'd0, s_axis_tdata[9:0]} < SLOT_LIMIT;
    incoming.slot_live    = s_axis_tdata[10];
    incoming.wanted_valid = s_axis_tdata[11];
    incoming.wanted_mip   = s_axis_tdata[15:12];
    incoming.lod_base     = s_axis_tdata[19:16];
    incoming.tex_format   = s_axis_tdata[23:20];
    incoming.phys_width   = s_axis_tdata[38:24];
    incoming.phys_height  = s_axis_tdata[53:39];
    incoming.phys_mips    = s_axis_tdata[57:54];
  end

  assign s_axis_tready = (count != 2'd2) && !ctl.clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head_valid    = count != 2'd0;
  assign head          = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (ctl.pop) begin
        rptr <= ~rptr;
      end
      case ({push, ctl.pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= incoming;
    end
  end

endmodule

// File: hw/rtl/mrf_back.sv
// Execution side: clears the slot table, then reads and updates one slot per item, writing it back if in range.
module mrf_back
  import mrf_pkg::*;
#(
  parameter int DEPTH = SLOTS_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  item_t            head,
  output back_ctl_t        ctl,
  input  logic [REG_W-1:0] hold_step,
  input  logic [REG_W-1:0] hold_limit,
  input  logic             out_ready,
  output logic             out_valid,
  output res_t             out_res
);

  localparam int RW = $bits(rec_t);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  item_t           cur;
  logic [AW-1:0]   clr_addr;
  logic            fire;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [RW-1:0]   wdata;
  logic [AW-1:0]   raddr;
  logic [RW-1:0]   rdata;
  rec_t            r;
  rec_t            n;
  res_t            res;
  logic [3:0]      top;
  logic [3:0]      clamp;
  logic [7:0]      hsum;
  logic [6:0]      hsat;
  logic            at_lim;
  logic            room;
  logic [14:0]     sw;
  logic [14:0]     sh;
  logic            begin_ok;

  mrf_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ctl.pop      = (state == ST_IDLE) && head_valid;
  assign ctl.clearing = state == ST_CLEAR;
  assign fire         = (state == ST_EXEC) && (!out_valid || out_ready);
  assign raddr        = (state == ST_IDLE) ? head.slot[AW-1:0] : cur.slot[AW-1:0];

  always_comb begin
    if (state == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = fire && cur.in_range;
      waddr = cur.slot[AW-1:0];
      wdata = RW'(n);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:  if (head_valid) state_next = ST_EXEC;
      ST_EXEC:  if (fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    r        = rec_t'(rdata);
    n        = r;
    res      = '0;
    top      = (r.total == 4'd0) ? 4'd0 : r.total - 4'd1;
    clamp    = (cur.wanted_mip > top) ? top : cur.wanted_mip;
    hsum     = {1'b0, r.hold} + {1'b0, hold_step};
    hsat     = (hsum > {1'b0, hold_limit}) ? hold_limit : hsum[6:0];
    at_lim   = hsat >= hold_limit;
    room     = ({1'b0, r.target} + 5'd1) < {1'b0, r.total};
    sw       = r.width >> cur.lod_base;
    sh       = r.height >> cur.lod_base;
    if (sw == 15'd0) sw = 15'd1;
    if (sh == 15'd0) sh = 15'd1;
    begin_ok = cur.slot_live && r.alive && !r.pending && (cur.lod_base < r.total) &&
               (cur.tex_format == r.format) && (cur.phys_width == sw) &&
               (cur.phys_height == sh) && (cur.phys_mips != 4'd0) &&
               (cur.phys_mips <= r.total - cur.lod_base);
    case (cur.op)
      OP_FEEDBACK: begin
        if (r.alive) begin
          res.accepted = 1'b1;
          if (cur.wanted_valid) begin
            res.sampled = 1'b1;
            if (clamp < r.target) begin
              n.target     = clamp;
              n.hold       = 7'd0;
              res.upgraded = 1'b1;
            end else if (clamp > r.target) begin
              n.hold = hsat;
              if (at_lim) begin
                n.target       = r.target + 4'd1;
                n.hold         = 7'd0;
                res.downgraded = 1'b1;
              end
            end else begin
              n.hold = 7'd0;
            end
          end else begin
            n.hold = hsat;
            if (at_lim && room) begin
              n.target       = r.target + 4'd1;
              n.hold         = 7'd0;
              res.downgraded = 1'b1;
            end
          end
          n.demand = n.alive && (n.target != n.resident);
        end
      end
      OP_RESIDENT: begin
        if (r.alive || cur.lod_base == 4'd0) begin
          if (!r.alive) begin
            n.format = cur.tex_format;
            n.width  = cur.phys_width;
            n.height = cur.phys_height;
            n.total  = cur.phys_mips;
            n.target = 4'd0;
          end
          n.resident   = cur.lod_base;
          n.hold       = 7'd0;
          n.pending    = 1'b0;
          n.alive      = (n.total != 4'd0) && (n.width != 15'd0) && (n.height != 15'd0) &&
                         (cur.phys_mips != 4'd0) && (cur.phys_width != 15'd0) &&
                         (cur.phys_height != 15'd0) && (cur.tex_format == n.format);
          n.demand     = n.alive && (n.target != n.resident);
          res.accepted = 1'b1;
        end
      end
      OP_BEGIN: begin
        if (begin_ok) begin
          n.pending    = 1'b1;
          res.accepted = 1'b1;
        end
      end
      OP_END: begin
        if (cur.slot_live) begin
          n.pending = 1'b0;
          if (r.alive && (r.target != r.resident)) begin
            n.demand = 1'b1;
          end
          res.accepted = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (cur.slot_live) begin
          n            = '0;
          res.accepted = 1'b1;
        end
      end
      default: begin
        n = r;
      end
    endcase
    res.target_mip   = n.target;
    res.resident_mip = n.resident;
    res.demand       = n.demand;
    if (!cur.in_range) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur <= head;
    end
    if (fire) begin
      out_res <= res;
    end
  end

endmodule

// File: hw/rtl/mrf_checker.sv
// Port-level assertions for the mip residency feedback policy block, bound to the top level.
module mrf_checker
  import mrf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_ready_low_after_reset: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("input ready while the slot table is being cleared");

  a_refused_has_no_outcome: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[12:10] == 3'd0))
    else $error("refused transaction reports a feedback outcome");

  a_up_down_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[10] && m_axis_tdata[11]))
    else $error("transaction both upgraded and downgraded");

  a_out_valid_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result transaction dropped or changed");

endmodule

bind mip_residency_feedback_policy_core mrf_checker u_mrf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: sim/mip_residency_feedback_policy_core_tb.sv
// Self-checking stream testbench for the mip residency feedback policy core.
module mip_residency_feedback_policy_core_tb;
  import mrf_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_MAX     = 8;

  typedef struct packed {
    op_t         func;
    logic [9:0]  slot;
    logic        slot_live;
    logic        wanted_valid;
    logic [3:0]  wanted_mip;
    logic [3:0]  lod_base;
    logic [3:0]  tex_format;
    logic [14:0] phys_width;
    logic [14:0] phys_height;
    logic [3:0]  phys_mips;
  } policy_item_t;

  typedef struct packed {
    logic       sampled;
    logic       downgraded;
    logic       upgraded;
    logic       demand;
    logic [3:0] resident_mip;
    logic [3:0] target_mip;
    logic       accepted;
  } policy_res_t;

  typedef struct packed {
    logic        alive;
    logic        pending;
    logic [3:0]  format;
    logic [14:0] width;
    logic [14:0] height;
    logic [3:0]  total;
    logic [3:0]  target;
    logic [3:0]  resident;
    logic [6:0]  hold;
    logic        demand;
  } slot_rec_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = FUNC_FEEDBACK;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_index = CFG_HOLD_STEP;
  logic [REG_W-1:0]       cfg_data = '0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;

  slot_rec_t        residency [SLOTS_DEFAULT];
  logic [REG_W-1:0] hold_step_reg  = HOLD_STEP_RESET;
  logic [REG_W-1:0] hold_limit_reg = HOLD_LIMIT_RESET;
  policy_res_t      expected_results [$];
  logic [9:0]       slot_pool [POOL_MAX];
  int               pool_size = 1;
  bit               idle_en = 1'b1;
  int               stall_left = 0;
  int unsigned      cycle_count = 0;
  int unsigned      failures = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_checked = 0;
  int unsigned      n_upgrades = 0;
  int unsigned      n_downgrades = 0;
  int unsigned      n_opened = 0;
  policy_res_t      got_res;
  policy_res_t      want_res;
  op_t              all_ops [5] = '{OP_FEEDBACK, OP_RESIDENT, OP_BEGIN, OP_END, OP_REMOVE};

  mip_residency_feedback_policy_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res = policy_res_t'(m_axis_tdata[12:0]);
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("Unexpected result transaction: %013b", got_res);
        end
      end else begin
        want_res = expected_results.pop_front();
        n_checked++;
        if (got_res !== want_res) begin
          failures++;
          if (failures <= 10) begin
            $display("Mismatch on result %0d:", n_checked);
            $display("  expected acc=%0b tgt=%0d res=%0d dem=%0b up=%0b dn=%0b smp=%0b",
                     want_res.accepted, want_res.target_mip, want_res.resident_mip,
                     want_res.demand, want_res.upgraded, want_res.downgraded,
                     want_res.sampled);
            $display("  got      acc=%0b tgt=%0d res=%0d dem=%0b up=%0b dn=%0b smp=%0b",
                     got_res.accepted, got_res.target_mip, got_res.resident_mip,
                     got_res.demand, got_res.upgraded, got_res.downgraded,
                     got_res.sampled);
          end
        end
      end
    end
  end

  function automatic logic [14:0] shifted_dim(logic [14:0] d, logic [3:0] sh);
    logic [14:0] v;
    v = d >> sh;
    return (v == 15'd0) ? 15'd1 : v;
  endfunction

  function automatic int stepped_hold(logic [6:0] hold);
    int h;
    h = int'(hold) + int'(hold_step_reg);
    if (h > int'(hold_limit_reg)) h = int'(hold_limit_reg);
    return h;
  endfunction

  function automatic policy_res_t predict_mip_policy(policy_item_t it);
    policy_res_t r;
    slot_rec_t   rec;
    int          h;
    logic [3:0]  c;
    logic [3:0]  top;
    r = '0;
    rec = residency[it.slot];
    case (it.func)
      OP_FEEDBACK: begin
        if (rec.alive) begin
          r.accepted = 1'b1;
          if (it.wanted_valid) begin
            top = (rec.total == 4'd0) ? 4'd0 : rec.total - 4'd1;
            c = (it.wanted_mip > top) ? top : it.wanted_mip;
            r.sampled = 1'b1;
            if (c < rec.target) begin
              rec.target = c;
              rec.hold = '0;
              r.upgraded = 1'b1;
            end else if (c > rec.target) begin
              h = stepped_hold(rec.hold);
              rec.hold = 7'(h);
              if (h >= int'(hold_limit_reg)) begin
                rec.target = rec.target + 4'd1;
                rec.hold = '0;
                r.downgraded = 1'b1;
              end
            end else begin
              rec.hold = '0;
            end
          end else begin
            h = stepped_hold(rec.hold);
            rec.hold = 7'(h);
            if (h >= int'(hold_limit_reg) && int'(rec.target) + 1 < int'(rec.total)) begin
              rec.target = rec.target + 4'd1;
              rec.hold = '0;
              r.downgraded = 1'b1;
            end
          end
          rec.demand = rec.alive && (rec.target != rec.resident);
        end
      end
      OP_RESIDENT: begin
        if (rec.alive || it.lod_base == 4'd0) begin
          if (!rec.alive) begin
            rec.format = it.tex_format;
            rec.width  = it.phys_width;
            rec.height = it.phys_height;
            rec.total  = it.phys_mips;
            rec.target = '0;
          end
          rec.resident = it.lod_base;
          rec.hold = '0;
          rec.pending = 1'b0;
          rec.alive = rec.total != 0 && rec.width != 0 && rec.height != 0 &&
                      it.phys_mips != 0 && it.phys_width != 0 && it.phys_height != 0 &&
                      it.tex_format == rec.format;
          rec.demand = rec.alive && (rec.target != rec.resident);
          r.accepted = 1'b1;
        end
      end
      OP_BEGIN: begin
        if (it.slot_live && rec.alive && !rec.pending && it.lod_base < rec.total &&
            it.tex_format == rec.format &&
            it.phys_width == shifted_dim(rec.width, it.lod_base) &&
            it.phys_height == shifted_dim(rec.height, it.lod_base) &&
            it.phys_mips != 0 &&
            int'(it.phys_mips) <= int'(rec.total) - int'(it.lod_base)) begin
          rec.pending = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_END: begin
        if (it.slot_live) begin
          rec.pending = 1'b0;
          if (rec.alive && rec.target != rec.resident) rec.demand = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (it.slot_live) begin
          rec = '0;
          r.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    residency[it.slot] = rec;
    r.target_mip = rec.target;
    r.resident_mip = rec.resident;
    r.demand = rec.demand;
    return r;
  endfunction

  function automatic policy_item_t mk_item(op_t f, int s, int live, int wv, int wm, int base,
                                           int fmt, int pw, int ph, int pm);
    policy_item_t it;
    it.func = f;
    it.slot = 10'(s);
    it.slot_live = 1'(live);
    it.wanted_valid = 1'(wv);
    it.wanted_mip = 4'(wm);
    it.lod_base = 4'(base);
    it.tex_format = 4'(fmt);
    it.phys_width = 15'(pw);
    it.phys_height = 15'(ph);
    it.phys_mips = 4'(pm);
    return it;
  endfunction

  function automatic int random_dim();
    if ($urandom_range(0, 1) == 0) return $urandom_range(1, 64);
    return $urandom_range(1, 16384);
  endfunction

  function automatic policy_item_t gen_item();
    policy_item_t it;
    slot_rec_t    rec;
    int           pick;
    int           tot;
    int           sel;
    it.func = all_ops[$urandom_range(0, 4)];
    it.slot_live = 1'($urandom_range(0, 1));
    it.wanted_valid = 1'($urandom_range(0, 1));
    it.wanted_mip = 4'($urandom_range(0, 15));
    it.lod_base = 4'($urandom_range(0, 15));
    it.tex_format = 4'($urandom_range(0, 15));
    it.phys_width = 15'($urandom_range(0, 16384));
    it.phys_height = 15'($urandom_range(0, 16384));
    it.phys_mips = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) it.slot = 10'($urandom_range(0, 1023));
    else it.slot = slot_pool[$urandom_range(0, pool_size - 1)];
    rec = residency[it.slot];
    tot = rec.total;
    pick = $urandom_range(0, 99);
    if (pick < 52 && !rec.alive && $urandom_range(0, 4) != 0) pick = 55;
    if (pick < 52) begin
      it.func = OP_FEEDBACK;
      it.wanted_valid = ($urandom_range(0, 9) < 7);
      sel = $urandom_range(0, 9);
      if (sel < 5 && rec.target < 4'd15)
        it.wanted_mip = 4'($urandom_range(int'(rec.target) + 1, 15));
      else if (sel < 7) it.wanted_mip = rec.target;
    end else if (pick < 64) begin
      it.func = OP_RESIDENT;
      if (!rec.alive) begin
        if ($urandom_range(0, 9) != 0) it.lod_base = 4'd0;
        it.phys_width = 15'(random_dim());
        it.phys_height = 15'(random_dim());
        it.phys_mips = 4'($urandom_range(1, 15));
        case ($urandom_range(0, 19))
          0: it.phys_width = 15'd0;
          1: it.phys_height = 15'd0;
          2: it.phys_mips = 4'd0;
          default: begin
          end
        endcase
      end else begin
        if ($urandom_range(0, 4) != 0) it.lod_base = 4'($urandom_range(0, tot - 1));
        if ($urandom_range(0, 9) != 0) it.tex_format = rec.format;
        it.phys_width = 15'(random_dim());
        it.phys_height = 15'(random_dim());
        it.phys_mips = 4'($urandom_range(1, 15));
      end
    end else if (pick < 76) begin
      it.func = OP_BEGIN;
      if (rec.alive) begin
        it.slot_live = 1'b1;
        it.lod_base = 4'($urandom_range(0, tot - 1));
        it.tex_format = rec.format;
        it.phys_width = shifted_dim(rec.width, it.lod_base);
        it.phys_height = shifted_dim(rec.height, it.lod_base);
        it.phys_mips = 4'($urandom_range(1, tot - int'(it.lod_base)));
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 5))
            0: it.slot_live = 1'b0;
            1: it.lod_base = 4'($urandom_range(0, 15));
            2: it.tex_format = it.tex_format + 4'd1;
            3: it.phys_width = it.phys_width + 15'd1;
            4: it.phys_mips = 4'd0;
            default: it.phys_mips = rec.total - it.lod_base + 4'd1;
          endcase
        end
      end
    end else if (pick < 88) begin
      it.func = OP_END;
      it.slot_live = ($urandom_range(0, 6) != 0);
    end else if (pick < 95) begin
      it.func = OP_REMOVE;
      it.slot_live = ($urandom_range(0, 3) != 0);
    end
    return it;
  endfunction

  // Entered and left at a falling edge; tvalid stays high between back-to-back items.
  task automatic send_item(policy_item_t it);
    policy_res_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {6'd0, it.phys_mips, it.phys_height, it.phys_width, it.tex_format,
                     it.lod_base, it.wanted_mip, it.wanted_valid, it.slot_live, it.slot};
    do @(posedge clk); while (!s_axis_tready);
    r = predict_mip_policy(it);
    expected_results = {expected_results, r};
    n_sent++;
    if (r.upgraded) n_upgrades++;
    if (r.downgraded) n_downgrades++;
    if (it.func == OP_BEGIN && r.accepted) n_opened++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_holds(int step, int limit);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HOLD_STEP;
    cfg_data <= REG_W'(step);
    hold_step_reg = REG_W'(step);
    @(negedge clk);
    cfg_index <= CFG_HOLD_LIMIT;
    cfg_data <= REG_W'(limit);
    hold_limit_reg = REG_W'(limit);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_items(int count, int pool);
    pool_size = pool;
    slot_pool[0] = 10'd0;
    slot_pool[1] = 10'd1023;
    for (int i = 2; i < POOL_MAX; i++) slot_pool[i] = 10'($urandom_range(0, 1023));
    for (int i = 0; i < count; i++) send_item(gen_item());
    drain_results();
  endtask

  task automatic test_directed();
    send_item(mk_item(OP_FEEDBACK, 0, 1, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_RESIDENT, 5, 1, 0, 0, 3, 2, 64, 64, 7));
    send_item(mk_item(OP_RESIDENT, 0, 0, 0, 0, 0, 15, 16384, 16384, 15));
    send_item(mk_item(OP_RESIDENT, 1023, 1, 0, 0, 0, 0, 0, 8, 4));
    send_item(mk_item(OP_FEEDBACK, 0, 1, 1, 15, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FEEDBACK, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FEEDBACK, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_RESIDENT, 0, 1, 0, 0, 2, 15, 1, 1, 1));
    send_item(mk_item(OP_BEGIN, 0, 1, 0, 0, 2, 15, 4096, 4096, 13));
    send_item(mk_item(OP_BEGIN, 0, 1, 0, 0, 2, 15, 4096, 4096, 13));
    send_item(mk_item(OP_END, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_END, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_BEGIN, 0, 1, 0, 0, 2, 15, 4096, 4095, 13));
    send_item(mk_item(OP_BEGIN, 0, 1, 0, 0, 15, 15, 1, 1, 1));
    send_item(mk_item(OP_BEGIN, 0, 0, 0, 0, 2, 15, 4096, 4096, 13));
    drain_results();
    set_holds(127, 127);
    send_item(mk_item(OP_FEEDBACK, 0, 1, 1, 15, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FEEDBACK, 0, 1, 1, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FEEDBACK, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_RESIDENT, 2, 1, 0, 0, 0, 3, 1, 1, 1));
    send_item(mk_item(OP_FEEDBACK, 2, 1, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_FEEDBACK, 2, 1, 1, 9, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_RESIDENT, 2, 1, 0, 0, 0, 4, 1, 1, 1));
    send_item(mk_item(OP_NONE, 0, 1, 1, 3, 1, 15, 5, 5, 5));
    send_item(mk_item(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_REMOVE, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  task automatic test_default_hold();
    set_holds(HOLD_STEP_RESET, HOLD_LIMIT_RESET);
    run_items(320, 3);
  endtask

  task automatic test_hold_extremes();
    set_holds(1, 1);
    run_items(150, 6);
    set_holds(1, 127);
    run_items(120, 4);
    set_holds(127, 127);
    run_items(150, 6);
    set_holds(127, 1);
    run_items(150, 6);
  endtask

  task automatic test_zero_registers();
    set_holds(0, 0);
    run_items(80, 4);
  endtask

  task automatic test_random_registers();
    for (int i = 0; i < 3; i++) begin
      set_holds($urandom_range(1, 127), $urandom_range(1, 127));
      run_items(50, 5);
    end
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    set_holds($urandom_range(1, 32), $urandom_range(8, 127));
    run_items(130, 4);
  endtask

  initial begin
    foreach (residency[i]) residency[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_default_hold();
    test_hold_extremes();
    test_zero_registers();
    test_random_registers();
    test_no_idle();
    if (expected_results.size() != 0) failures++;
    $display("Sent %0d items and checked %0d results under the reset hold setting and %s",
             n_sent, n_checked, "eleven written ones.");
    $display("Seen %0d upgrades, %0d downgrades and %0d replacements opened; %0d failures.",
             n_upgrades, n_downgrades, n_opened, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
